### src/go_to_goal_steering_top_assert.svh
// assertion macros for the steering block
`ifndef GO_TO_GOAL_STEERING_TOP_ASSERT_SVH
`define GO_TO_GOAL_STEERING_TOP_ASSERT_SVH
`define G2G_ASSERT_IMPL(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("assertion failed");
`define G2G_ASSERT_NEXT(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("assertion failed");
`endif

### src/g2g_pkg.sv
package g2g_pkg;
    localparam int CORDIC_STEPS = 16;
    localparam int ITW = 5;
    localparam logic [1:0] MODE_POSE = 2'd0;
    localparam logic [1:0] MODE_TARGET = 2'd1;
    localparam logic [1:0] MODE_TICK = 2'd2;
    localparam logic [1:0] CFG_LIN = 2'd0;
    localparam logic [1:0] CFG_ANG = 2'd1;
    localparam logic [1:0] CFG_RAD = 2'd2;
    localparam logic signed [17:0] ANG_HALF_PI = 18'sd12868;
    localparam logic signed [17:0] ANG_PI = 18'sd25736;
    localparam logic signed [17:0] ANG_TWO_PI = 18'sd51472;

    typedef struct packed {
        logic load;
        logic sqrt_step;
        logic cordic_step;
        logic finish;
    } g2g_cmd_t;

    typedef struct packed {
        logic cordic_done;
        logic last;
    } g2g_sts_t;

    function automatic logic signed [17:0] atan_lut(input logic [ITW-1:0] i);
        case (i)
            5'd0: atan_lut = 18'sd6434;
            5'd1: atan_lut = 18'sd3798;
            5'd2: atan_lut = 18'sd2007;
            5'd3: atan_lut = 18'sd1019;
            5'd4: atan_lut = 18'sd511;
            5'd5: atan_lut = 18'sd256;
            5'd6: atan_lut = 18'sd128;
            5'd7: atan_lut = 18'sd64;
            5'd8: atan_lut = 18'sd32;
            5'd9: atan_lut = 18'sd16;
            5'd10: atan_lut = 18'sd8;
            5'd11: atan_lut = 18'sd4;
            5'd12: atan_lut = 18'sd2;
            5'd13: atan_lut = 18'sd1;
            default: atan_lut = 18'sd0;
        endcase
    endfunction
endpackage

### src/g2g_datapath.sv
module g2g_datapath (
    input  logic                aclk,
    input  g2g_pkg::g2g_cmd_t   cmd,
    output g2g_pkg::g2g_sts_t   sts,
    input  logic signed [15:0]  robot_x,
    input  logic signed [15:0]  robot_y,
    input  logic signed [15:0]  robot_heading,
    input  logic signed [15:0]  goal_x,
    input  logic signed [15:0]  goal_y,
    input  logic [7:0]          lin_gain,
    input  logic [7:0]          ang_gain,
    input  logic [14:0]         radius,
    output logic [16:0]         speed,
    output logic signed [18:0]  turn,
    output logic                reached
);
    import g2g_pkg::*;

    logic signed [16:0] dx, dy;
    logic signed [33:0] dx2, dy2;
    logic [29:0] rsq;
    logic [34:0] sq_reg, sq_next;
    logic [17:0] root_reg, root_next;
    logic signed [26:0] cx_reg, cx_next, cy_reg, cy_next;
    logic signed [17:0] cz_reg, cz_next;
    logic [ITW-1:0] it_reg, it_next;
    logic near_reg, near_next;
    logic [16:0] speed_reg, speed_next;
    logic signed [18:0] turn_reg, turn_next;
    logic [17:0] tbit;
    logic [35:0] tsq;
    logic signed [26:0] xs, ys, x0, y0;
    logic [25:0] prod_l;
    logic signed [18:0] err0, err;
    logic signed [27:0] prod_a, tsh;

    assign dx = 17'(goal_x) - 17'(robot_x);
    assign dy = 17'(goal_y) - 17'(robot_y);
    assign dx2 = dx * dx;
    assign dy2 = dy * dy;
    assign rsq = radius * radius;
    assign tbit = root_reg | (18'd1 << (17 - it_reg));
    assign tsq = tbit * tbit;
    assign xs = cx_reg >>> it_reg;
    assign ys = cy_reg >>> it_reg;
    assign x0 = 27'(dx) <<< 8;
    assign y0 = 27'(dy) <<< 8;
    assign prod_l = root_reg * lin_gain;
    assign err0 = 19'(cz_reg) - 19'(robot_heading);
    assign err = (err0 > 19'(ANG_PI)) ? err0 - 19'(ANG_TWO_PI) :
                 (err0 < -19'(ANG_PI)) ? err0 + 19'(ANG_TWO_PI) : err0;
    assign prod_a = err * $signed({1'b0, ang_gain});
    assign tsh = prod_a >>> 4;

    always_comb begin
        sq_next = sq_reg; root_next = root_reg; cx_next = cx_reg;
        cy_next = cy_reg; cz_next = cz_reg; it_next = it_reg;
        near_next = near_reg; speed_next = speed_reg; turn_next = turn_reg;
        if (cmd.load) begin
            sq_next = 35'(dx2) + 35'(dy2);
            near_next = (35'(dx2) + 35'(dy2)) <= 35'(rsq);
            root_next = '0;
            it_next = '0;
            cx_next = x0; cy_next = y0; cz_next = '0;
            if (dx < 0) begin
                if (dy >= 0) begin
                    cx_next = y0; cy_next = -x0; cz_next = ANG_HALF_PI;
                end else begin
                    cx_next = -y0; cy_next = x0; cz_next = -ANG_HALF_PI;
                end
            end
        end else if (cmd.sqrt_step || cmd.cordic_step) begin
            it_next = it_reg + 1'b1;
            if (cmd.sqrt_step && it_reg < 5'd18 && tsq <= 36'(sq_reg))
                root_next = root_reg | (18'd1 << (17 - it_reg));
            if (cmd.cordic_step) begin
                if (cy_reg >= 0) begin
                    cx_next = cx_reg + ys; cy_next = cy_reg - xs;
                    cz_next = cz_reg + atan_lut(it_reg);
                end else begin
                    cx_next = cx_reg - ys; cy_next = cy_reg + xs;
                    cz_next = cz_reg - atan_lut(it_reg);
                end
            end
        end else if (cmd.finish) begin
            speed_next = (prod_l[25:4] > 22'd131071) ? 17'd131071 : prod_l[20:4];
            if (tsh > 28'sd262143) turn_next = 19'sd262143;
            else if (tsh < -28'sd262144) turn_next = -19'sd262144;
            else turn_next = tsh[18:0];
            if (near_reg) begin
                speed_next = '0; turn_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        sq_reg <= sq_next; root_reg <= root_next; cx_reg <= cx_next;
        cy_reg <= cy_next; cz_reg <= cz_next; it_reg <= it_next;
        near_reg <= near_next; speed_reg <= speed_next; turn_reg <= turn_next;
    end

    assign sts.cordic_done = (32'(it_reg) >= CORDIC_STEPS);
    assign sts.last = (32'(it_reg) == 32'(CORDIC_STEPS > 18 ? CORDIC_STEPS : 18) - 1);
    assign speed = speed_reg;
    assign turn = turn_reg;
    assign reached = near_reg;
endmodule

### src/g2g_ctrl.sv
module g2g_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic              out_taken,
    input  g2g_pkg::g2g_sts_t sts,
    output g2g_pkg::g2g_cmd_t cmd,
    output logic              busy,
    output logic              out_valid
);
    import g2g_pkg::*;
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001, S_RUN = 4'b0010, S_FIN = 4'b0100, S_OUT = 4'b1000
    } state_t;
    state_t state_reg, state_next;
    logic it_run;

    assign it_run = state_reg == S_RUN;
    always_comb begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            S_IDLE: if (start) begin cmd.load = 1'b1; state_next = S_RUN; end
            S_RUN: begin
                cmd.sqrt_step = 1'b1;
                cmd.cordic_step = 1'b1;
                if (sts.last) state_next = S_FIN;
            end
            S_FIN: begin cmd.finish = 1'b1; state_next = S_OUT; end
            S_OUT: if (out_taken) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
        // cordic runs only for its step count, sqrt for its 18 bits
        if (it_run && sts.cordic_done) cmd.cordic_step = 1'b0;
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else state_reg <= state_next;
    end
    assign busy = state_reg != S_IDLE;
    assign out_valid = state_reg == S_OUT;
endmodule

### src/go_to_goal_steering_top.sv
// proportional go-to-goal steering: pose words, and target words with s_target_present set,
// update stored state; a control tick with pose and goal known runs an 18-step bit-serial
// square root alongside the cordic bearing loop, both driven by the shared step counter,
// then holds its word on m_ until taken; ticks without a known pose or goal give nothing
module go_to_goal_steering_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_mode,
    input  logic signed [15:0] s_pos_x,
    input  logic signed [15:0] s_pos_y,
    input  logic signed [15:0] s_heading,
    input  logic               s_target_present,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [16:0]        m_linear_speed,
    output logic signed [18:0] m_turn_rate,
    output logic               m_reached,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [14:0]        cfg_data
);
    import g2g_pkg::*;
    logic [7:0] lin_reg, ang_reg;
    logic [14:0] rad_reg;
    logic signed [15:0] rx_reg, ry_reg, rh_reg, gx_reg, gy_reg;
    logic pk_reg, gk_reg, acc, busy, start;
    g2g_cmd_t cmd;
    g2g_sts_t sts;

    // one word at a time
    assign s_ready = !busy;
    assign acc = s_valid && s_ready;
    assign start = acc && s_mode == MODE_TICK && pk_reg && gk_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lin_reg <= 8'd32; ang_reg <= 8'd96; rad_reg <= 15'd1024;
            rx_reg <= '0; ry_reg <= '0; rh_reg <= '0; gx_reg <= '0; gy_reg <= '0;
            pk_reg <= 1'b0; gk_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_LIN: lin_reg <= cfg_data[7:0];
                    CFG_ANG: ang_reg <= cfg_data[7:0];
                    CFG_RAD: rad_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (acc && s_mode == MODE_POSE) begin
                rx_reg <= s_pos_x; ry_reg <= s_pos_y; rh_reg <= s_heading;
                pk_reg <= 1'b1;
            end
            if (acc && s_mode == MODE_TARGET && s_target_present) begin
                gx_reg <= s_pos_x; gy_reg <= s_pos_y; gk_reg <= 1'b1;
            end
        end
    end

    g2g_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .start(start), .out_taken(m_ready),
        .sts(sts), .cmd(cmd), .busy(busy), .out_valid(m_valid)
    );

    g2g_datapath u_dp (
        .aclk(aclk), .cmd(cmd), .sts(sts),
        .robot_x(rx_reg), .robot_y(ry_reg), .robot_heading(rh_reg),
        .goal_x(gx_reg), .goal_y(gy_reg),
        .lin_gain(lin_reg), .ang_gain(ang_reg), .radius(rad_reg),
        .speed(m_linear_speed), .turn(m_turn_rate), .reached(m_reached)
    );
endmodule

### src/go_to_goal_steering_top_checker.sv
`include "go_to_goal_steering_top_assert.svh"
module go_to_goal_steering_top_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [16:0] m_linear_speed,
    input logic        m_reached
);
    `G2G_ASSERT_IMPL(a_no_in_while_out, aclk, aresetn, m_valid, !s_ready)
    `G2G_ASSERT_IMPL(a_reached_zero, aclk, aresetn, m_valid && m_reached, m_linear_speed == 17'd0)
    `G2G_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid)
endmodule

bind go_to_goal_steering_top go_to_goal_steering_top_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_ready(s_ready), .m_valid(m_valid),
    .m_ready(m_ready), .m_linear_speed(m_linear_speed), .m_reached(m_reached)
);
